[sv/stbr_pkg.sv]
// ----------------------------------------------------------------------------
// stbr_pkg
// Shared types, constants and color helpers for the scanline timing and
// bitmap renderer.
// ----------------------------------------------------------------------------
package stbr_pkg;

  // Display geometry and palette size.
  localparam int SCREEN_WIDTH    = 240;
  localparam int SCREEN_HEIGHT   = 160;
  localparam int LINES_PER_FRAME = 228;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

  // Request codes carried by an input beat.
  typedef enum logic [1:0] {
    REQ_LINE   = 2'd0,
    REQ_HBLANK = 2'd1,
    REQ_PIXEL  = 2'd2,
    REQ_PAL_WR = 2'd3
  } req_t;

  // Background mode codes.
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_DIRECT  = 3'd3;
  localparam logic [2:0] MODE_PALETTE = 3'd4;

  // Register index of the background mode register.
  localparam logic REG_BG_MODE = 1'b0;

  // Result of the timing stage for one beat, before the color is known.
  typedef struct packed {
    logic [7:0]  line_number;
    logic        in_vblank;
    logic        in_hblank;
    logic        frame_done;
    logic        buffer_select;
    logic        pixel_valid;
    logic [15:0] pixel_address;
    logic        mode_error;
    logic        use_palette;
    logic [14:0] direct_color;
  } stbr_beat_t;

  // Widen a 5-bit channel to 8 bits by replicating its top bits.
  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // BGR555 to RGBA8888 with opaque alpha.
  function automatic logic [31:0] bgr555_to_rgba(input logic [14:0] raw);
    return {widen5(raw[4:0]), widen5(raw[9:5]), widen5(raw[14:10]), 8'hff};
  endfunction

endpackage

[sv/scanline_timing_bitmap_render.sv]
// A result passes the stage 1 register, loaded as its input beat is accepted,
// then enters the output register once that register is free or drains.
// Throughput: one beat per cycle while out_ready holds; the palette RAM's
// registered read sets stage 1, and an output register decouples the sides.
// Reset: timing state returns to the last line of a frame, the mode register
// to 0; palette valid bits clear at once, so there is no clearing pass.
// ----------------------------------------------------------------------------
// scanline_timing_bitmap_render
// Scanline timing engine with direct and paletted BGR555 pixel conversion.
// ----------------------------------------------------------------------------
module scanline_timing_bitmap_render (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_pixel_value,
  input  logic [7:0]  in_palette_index,
  input  logic [15:0] in_palette_color,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_line_number,
  output logic        out_in_vblank,
  output logic        out_in_hblank,
  output logic        out_frame_done,
  output logic        out_buffer_select,
  output logic        out_pixel_valid,
  output logic [15:0] out_pixel_address,
  output logic [31:0] out_pixel_rgba,
  output logic        out_mode_error,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import stbr_pkg::*;

  logic [2:0]  bg_mode_r;
  req_t        req;
  logic        accept;
  stbr_beat_t  beat;
  stbr_beat_t  s1_beat_r;
  logic        s1_valid_r;
  logic        s1_adv;
  logic [14:0] pal_color;
  logic [14:0] s1_color;
  logic        out_valid_r;
  logic [7:0]  out_line_r;
  logic        out_vblank_r;
  logic        out_hblank_r;
  logic        out_frame_r;
  logic        out_buf_r;
  logic        out_pvalid_r;
  logic [15:0] out_addr_r;
  logic [31:0] out_rgba_r;
  logic        out_merr_r;

  // Configuration register: written in the access phase, read back at any address with bit 2 clear.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_mode_r <= MODE_OFF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_BG_MODE)) begin
      bg_mode_r <= cfg_pwdata[2:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_BG_MODE) ? {29'd0, bg_mode_r} : 32'd0;

  // Handshake: stage 1 moves on when the output register is free or drains.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign req      = req_t'(in_req_type);

  stbr_timing u_timing (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req         (req),
    .pixel_value (in_pixel_value),
    .bg_mode     (bg_mode_r),
    .beat        (beat)
  );

  // Palette write and lookup both happen as the beat is accepted.
  stbr_palette u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept && (req == REQ_PAL_WR)),
    .wr_index (in_palette_index),
    .wr_color (in_palette_color),
    .rd_en    (accept && (req == REQ_PIXEL)),
    .rd_index (in_pixel_value[7:0]),
    .rd_color (pal_color)
  );

  // Stage 1 holds the timing result while the palette read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_beat_r <= beat;
    end
  end

  assign s1_color = s1_beat_r.use_palette ? pal_color : s1_beat_r.direct_color;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_line_r   <= s1_beat_r.line_number;
      out_vblank_r <= s1_beat_r.in_vblank;
      out_hblank_r <= s1_beat_r.in_hblank;
      out_frame_r  <= s1_beat_r.frame_done;
      out_buf_r    <= s1_beat_r.buffer_select;
      out_pvalid_r <= s1_beat_r.pixel_valid;
      out_addr_r   <= s1_beat_r.pixel_address;
      out_rgba_r   <= s1_beat_r.pixel_valid ? bgr555_to_rgba(s1_color) : 32'd0;
      out_merr_r   <= s1_beat_r.mode_error;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_number   = out_line_r;
  assign out_in_vblank     = out_vblank_r;
  assign out_in_hblank     = out_hblank_r;
  assign out_frame_done    = out_frame_r;
  assign out_buffer_select = out_buf_r;
  assign out_pixel_valid   = out_pvalid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_rgba    = out_rgba_r;
  assign out_mode_error    = out_merr_r;

endmodule

[sv/stbr_ram.sv]
// ----------------------------------------------------------------------------
// stbr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds without a read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/stbr_palette.sv]
// ----------------------------------------------------------------------------
// stbr_palette
// Palette store: RAM of BGR555 colors with per-entry valid bits so that an
// entry never written since reset reads as black.
// ----------------------------------------------------------------------------
module stbr_palette (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [15:0] wr_color,
  input  logic        rd_en,
  input  logic [7:0]  rd_index,
  output logic [14:0] rd_color
);
  import stbr_pkg::*;

  logic [PALETTE_ENTRIES-1:0] valid_r;
  logic                       hit_r;
  logic                       wr_in_range;
  logic                       rd_in_range;
  logic                       wr_go;
  logic [15:0]                ram_data;

  // Indexes past the palette are ignored on write and read as black.
  assign wr_in_range = {1'b0, wr_index} < 9'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, rd_index} < 9'(PALETTE_ENTRIES);
  assign wr_go       = wr_en && wr_in_range;

  stbr_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_go),
    .wr_addr (wr_index[PAL_AW-1:0]),
    .wr_data (wr_color),
    .rd_en   (rd_en),
    .rd_addr (rd_index[PAL_AW-1:0]),
    .rd_data (ram_data)
  );

  // Valid bits stand in for clearing the RAM at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_go) begin
      valid_r[wr_index[PAL_AW-1:0]] <= 1'b1;
    end
  end

  // The hit flag is sampled along with the RAM read so both hold together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= rd_in_range && valid_r[rd_index[PAL_AW-1:0]];
    end
  end

  assign rd_color = hit_r ? ram_data[14:0] : 15'd0;

endmodule

[sv/stbr_timing.sv]
// ----------------------------------------------------------------------------
// stbr_timing
// Line counter, blank flags, buffer select and column counter. Produces the
// timing and address part of the result for each accepted beat.
// ----------------------------------------------------------------------------
module stbr_timing (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  stbr_pkg::req_t      req,
  input  logic [15:0]         pixel_value,
  input  logic [2:0]          bg_mode,
  output stbr_pkg::stbr_beat_t beat
);
  import stbr_pkg::*;

  logic [7:0] line_r,   line_nxt;
  logic       vblank_r, vblank_nxt;
  logic       hblank_r, hblank_nxt;
  logic       front_r,  front_nxt;
  logic [7:0] column_r, column_nxt;

  logic [7:0]  line_inc;
  logic [15:0] address;
  logic        mode_draws;
  logic        mode_bad;
  logic        frame_wrap;

  assign line_inc   = line_r + 8'd1;
  assign frame_wrap = {1'b0, line_inc} >= 9'(LINES_PER_FRAME);
  assign mode_draws = (bg_mode == MODE_DIRECT) || (bg_mode == MODE_PALETTE);
  assign mode_bad   = !mode_draws && (bg_mode != MODE_OFF);
  assign address    = 16'({8'd0, line_r} * 16'(SCREEN_WIDTH)) + {8'd0, column_r};

  // Next state and result fields for the beat at the input.
  always_comb begin
    line_nxt   = line_r;
    vblank_nxt = vblank_r;
    hblank_nxt = hblank_r;
    front_nxt  = front_r;
    column_nxt = column_r;
    beat       = '0;
    case (req)
      REQ_LINE: begin
        hblank_nxt = 1'b0;
        column_nxt = 8'd0;
        line_nxt   = line_inc;
        if (line_inc == 8'(SCREEN_HEIGHT)) begin
          vblank_nxt = 1'b1;
        end
        if (frame_wrap) begin
          line_nxt   = 8'd0;
          vblank_nxt = 1'b0;
          front_nxt  = !front_r;
        end
        beat.frame_done = frame_wrap;
        beat.mode_error = ({1'b0, line_nxt} < 9'(SCREEN_HEIGHT)) && mode_bad;
      end
      REQ_HBLANK: begin
        hblank_nxt = 1'b1;
      end
      REQ_PIXEL: begin
        if ({1'b0, column_r} < 9'(SCREEN_WIDTH)) begin
          column_nxt = column_r + 8'd1;
        end
        if (({1'b0, line_r} < 9'(SCREEN_HEIGHT)) &&
            ({1'b0, column_r} < 9'(SCREEN_WIDTH)) && mode_draws) begin
          beat.pixel_valid   = 1'b1;
          beat.pixel_address = address;
          beat.use_palette   = (bg_mode == MODE_PALETTE);
          beat.direct_color  = pixel_value[14:0];
        end
      end
      default: begin
        // Palette writes leave the timing state alone.
      end
    endcase
    beat.line_number   = line_nxt;
    beat.in_vblank     = vblank_nxt;
    beat.in_hblank     = hblank_nxt;
    beat.buffer_select = front_nxt;
  end

  // Timing state updates on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= 8'(LINES_PER_FRAME - 1);
      vblank_r <= 1'b0;
      hblank_r <= 1'b0;
      front_r  <= 1'b0;
      column_r <= 8'd0;
    end else if (accept) begin
      line_r   <= line_nxt;
      vblank_r <= vblank_nxt;
      hblank_r <= hblank_nxt;
      front_r  <= front_nxt;
      column_r <= column_nxt;
    end
  end

endmodule
